[src/tpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

	// Default floor size
	localparam int GRID_ROWS_DEF = 32;
	localparam int GRID_COLS_DEF = 32;

	// Width used for position and room compares (grid edge is at most 256)
	localparam int POS_CMP_W = 9;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Command codes on the func field
	localparam logic [2:0] FN_PEN_UP   = 3'd0;
	localparam logic [2:0] FN_PEN_DOWN = 3'd1;
	localparam logic [2:0] FN_TURN_R   = 3'd2;
	localparam logic [2:0] FN_TURN_L   = 3'd3;
	localparam logic [2:0] FN_MOVE     = 3'd4;
	localparam logic [2:0] FN_READ     = 3'd5;
	localparam logic [2:0] FN_CLEAR    = 3'd6;

	// Heading codes
	localparam logic [1:0] HD_EAST  = 2'd0;
	localparam logic [1:0] HD_SOUTH = 2'd1;
	localparam logic [1:0] HD_WEST  = 2'd2;
	localparam logic [1:0] HD_NORTH = 2'd3;

	// Status codes
	localparam logic ST_DONE    = 1'b0;
	localparam logic ST_REFUSED = 1'b1;

	// Operation class after decode
	typedef enum logic [2:0] {
		OP_PEN_UP   = 3'd0,
		OP_PEN_DOWN = 3'd1,
		OP_TURN_R   = 3'd2,
		OP_TURN_L   = 3'd3,
		OP_MOVE     = 3'd4,
		OP_READ     = 3'd5,
		OP_CLEAR    = 3'd6,
		OP_NOP      = 3'd7
	} tpp_op_t;

	// Input item
	typedef struct packed {
		logic [2:0] func;
		logic [7:0] step_count;
		logic [4:0] query_row;
		logic [4:0] query_col;
	} tpp_cmd_t;

	// Result item
	typedef struct packed {
		logic       status;
		logic [4:0] pos_row;
		logic [4:0] pos_col;
		logic [1:0] heading;
		logic       pen_down;
		logic       cell_value;
	} tpp_rsp_t;

	// Decoded item held in the queue
	typedef struct packed {
		tpp_op_t    op;
		logic [7:0] steps;
		logic [4:0] qrow;
		logic [4:0] qcol;
		logic       q_in_grid;
	} tpp_item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} tpp_qstat_t;

endpackage

`default_nettype wire

[src/turtle_path_plotter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Turtle plotter on a GRID_ROWS x GRID_COLS one-bit floor. A command is taken
// when start is high and busy is low; every command gives exactly one result,
// shown on rsp for a single cycle while done is high, and the receiver must
// capture it then since it cannot hold results off. A front stage and a
// two-entry queue take commands while the back executes; busy rises only when
// both are full. The back ends pen, turn, reset and unused codes, reads outside
// the floor and refused or pen-up moves in its execute state; a read inside the
// floor adds a read-wait state, a pen-down east or west move a mark state that
// writes the span, and a pen-down north or south move marks its rows in turn,
// one floor row write per cycle on the single memory write port. The done pulse
// follows the last execution cycle. The floor is cleared through per-row flags,
// so reset and the reset command take effect at once with no clearing pass.
module turtle_path_plotter_top
	import tpp_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire tpp_cmd_t cmd,
	output logic          busy,
	output logic          done,
	output tpp_rsp_t      rsp
);

	tpp_qstat_t qstat;
	tpp_item_t  push_item;
	tpp_item_t  head_item;
	logic       push;
	logic       pop;

	// Accept and classify commands
	tpp_front #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.qstat (qstat),
		.push  (push),
		.item  (push_item)
	);

	// Buffer decoded items
	tpp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(push_item),
		.pop    (pop),
		.rd_item(head_item),
		.qstat  (qstat)
	);

	// Execute commands against the floor
	tpp_back #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.head  (head_item),
		.pop   (pop),
		.done  (done),
		.rsp   (rsp)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue pushed while full");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results closer than the shortest command");

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((GRID_ROWS > 32) || (32'(rsp.pos_row) < GRID_ROWS)))
		else $error("reported row outside the floor");
`endif

endmodule

`default_nettype wire

[src/tpp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpp_front
	import tpp_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire tpp_cmd_t   cmd,
	output logic            busy,
	input  wire tpp_qstat_t qstat,
	output logic            push,
	output tpp_item_t       item
);

	logic      vld_s1;
	tpp_item_t item_s1;
	tpp_item_t dec;
	logic      take;

	// Classify the command and check the read query against the grid
	always_comb begin
		dec.steps = cmd.step_count;
		dec.qrow  = cmd.query_row;
		dec.qcol  = cmd.query_col;
		dec.q_in_grid = (POS_CMP_W'(cmd.query_row) < POS_CMP_W'(GRID_ROWS)) &&
			(POS_CMP_W'(cmd.query_col) < POS_CMP_W'(GRID_COLS));
		unique case (cmd.func)
			FN_PEN_UP:   dec.op = OP_PEN_UP;
			FN_PEN_DOWN: dec.op = OP_PEN_DOWN;
			FN_TURN_R:   dec.op = OP_TURN_R;
			FN_TURN_L:   dec.op = OP_TURN_L;
			FN_MOVE:     dec.op = OP_MOVE;
			FN_READ:     dec.op = OP_READ;
			FN_CLEAR:    dec.op = OP_CLEAR;
			default:     dec.op = OP_NOP;
		endcase
	end

	// Hold off new items only while the stage is full and cannot drain
	assign busy = vld_s1 & qstat.full;
	assign take = start & ~busy;
	assign push = vld_s1 & ~qstat.full;
	assign item = item_s1;

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Capture the decoded item
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

[src/tpp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpp_fifo
	import tpp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire tpp_item_t wr_item,
	input  wire logic      pop,
	output tpp_item_t      rd_item,
	output tpp_qstat_t     qstat
);

	tpp_item_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rd_item     = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

[src/tpp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpp_back
	import tpp_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tpp_qstat_t qstat,
	input  wire tpp_item_t  head,
	output logic            pop,
	output logic            done,
	output tpp_rsp_t        rsp
);

	localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_RDWAIT = 4'b0100,
		S_MARK   = 4'b1000
	} tpp_state_t;

	tpp_state_t state_q, state_d;

	// Turtle and command registers
	tpp_item_t          cur_q;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [1:0]         head_q, head_d;
	logic               pen_q, pen_d;
	logic [ROW_W-1:0]   walk_q, walk_d;
	logic [7:0]         left_q, left_d;

	// Floor memory, one row per entry, with per-row valid flags
	logic [GRID_COLS-1:0] floor_mem [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_vld_q;
	logic [GRID_COLS-1:0] rd_q;
	logic                 rd_ok_q;

	logic                 rd_en, wr_en, clr_all;
	logic [ROW_W-1:0]     rd_addr, wr_addr;
	logic [GRID_COLS-1:0] wr_data;
	logic [GRID_COLS-1:0] eff_row, colbit, span;

	logic                 emit, status_d, cell_d;
	logic [POS_CMP_W-1:0] room;
	logic                 refuse, horiz;
	logic [COL_W-1:0]     end_col, lo_col, hi_col;
	logic [ROW_W-1:0]     end_row, next_walk;

	tpp_rsp_t rsp_q;
	logic     done_q;

	assign pop     = (state_q == S_IDLE) && !qstat.empty;
	assign eff_row = rd_ok_q ? rd_q : '0;
	assign horiz   = (head_q == HD_EAST) || (head_q == HD_WEST);

	// Room left before the edge and end position of the move
	always_comb begin
		case (head_q)
			HD_EAST:  room = POS_CMP_W'(GRID_COLS - 1) - POS_CMP_W'(col_q);
			HD_SOUTH: room = POS_CMP_W'(GRID_ROWS - 1) - POS_CMP_W'(row_q);
			HD_WEST:  room = POS_CMP_W'(col_q);
			default:  room = POS_CMP_W'(row_q);
		endcase
		refuse = POS_CMP_W'(cur_q.steps) > room;
		if (head_q == HD_EAST) begin
			end_col = COL_W'(POS_CMP_W'(col_q) + POS_CMP_W'(cur_q.steps));
		end else begin
			end_col = COL_W'(POS_CMP_W'(col_q) - POS_CMP_W'(cur_q.steps));
		end
		if (head_q == HD_SOUTH) begin
			end_row = ROW_W'(POS_CMP_W'(row_q) + POS_CMP_W'(cur_q.steps));
		end else begin
			end_row = ROW_W'(POS_CMP_W'(row_q) - POS_CMP_W'(cur_q.steps));
		end
		next_walk = (head_q == HD_SOUTH) ? walk_q + 1'b1 : walk_q - 1'b1;
	end

	// Build the column span of a horizontal stroke and the single column bit
	always_comb begin
		lo_col = (head_q == HD_EAST) ? col_q : end_col;
		hi_col = (head_q == HD_EAST) ? end_col : col_q;
		colbit = '0;
		colbit[col_q] = 1'b1;
		for (int j = 0; j < GRID_COLS; j++) begin
			span[j] = (COL_W'(j) >= lo_col) && (COL_W'(j) <= hi_col);
		end
	end

	// Sequence the current command
	always_comb begin
		state_d  = state_q;
		row_d    = row_q;
		col_d    = col_q;
		head_d   = head_q;
		pen_d    = pen_q;
		walk_d   = walk_q;
		left_d   = left_q;
		emit     = 1'b0;
		status_d = ST_DONE;
		cell_d   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = row_q;
		wr_en    = 1'b0;
		wr_addr  = walk_q;
		wr_data  = eff_row | colbit;
		clr_all  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				case (cur_q.op)
					OP_PEN_UP:   pen_d  = 1'b0;
					OP_PEN_DOWN: pen_d  = 1'b1;
					OP_TURN_R:   head_d = head_q + 2'd1;
					OP_TURN_L:   head_d = head_q + 2'd3;
					OP_CLEAR: begin
						row_d   = '0;
						col_d   = '0;
						head_d  = HD_EAST;
						pen_d   = 1'b0;
						clr_all = 1'b1;
					end
					OP_READ: begin
						if (cur_q.q_in_grid) begin
							rd_en   = 1'b1;
							rd_addr = ROW_W'(cur_q.qrow);
							emit    = 1'b0;
							state_d = S_RDWAIT;
						end
					end
					OP_MOVE: begin
						if (refuse) begin
							status_d = ST_REFUSED;
						end else if (!pen_q) begin
							if (horiz) begin
								col_d = end_col;
							end else begin
								row_d = end_row;
							end
						end else begin
							// open the stroke at the start row
							rd_en   = 1'b1;
							rd_addr = row_q;
							walk_d  = row_q;
							left_d  = cur_q.steps;
							emit    = 1'b0;
							state_d = S_MARK;
						end
					end
					default: ;
				endcase
			end
			S_RDWAIT: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				cell_d  = eff_row[COL_W'(cur_q.qcol)];
			end
			S_MARK: begin
				wr_en = 1'b1;
				if (horiz) begin
					// mark the whole span of the row at once
					wr_data = eff_row | span;
					col_d   = end_col;
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (left_q != '0) begin
					// mark this row and fetch the next one
					rd_en   = 1'b1;
					rd_addr = next_walk;
					walk_d  = next_walk;
					left_d  = left_q - 1'b1;
				end else begin
					row_d   = walk_q;
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Update control and turtle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			head_q    <= HD_EAST;
			pen_q     <= 1'b0;
			row_vld_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			head_q  <= head_d;
			pen_q   <= pen_d;
			done_q  <= emit;
			if (clr_all) begin
				row_vld_q <= '0;
			end else if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Hold command payload, walk counters and the result
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		walk_q <= walk_d;
		left_q <= left_d;
		if (emit) begin
			rsp_q.status     <= status_d;
			rsp_q.pos_row    <= 5'(row_d);
			rsp_q.pos_col    <= 5'(col_d);
			rsp_q.heading    <= head_d;
			rsp_q.pen_down   <= pen_d;
			rsp_q.cell_value <= cell_d;
		end
	end

	// Floor memory write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			floor_mem[wr_addr] <= wr_data;
		end
	end

	// Floor memory read port, with the row flag sampled alongside
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q    <= floor_mem[rd_addr];
			rd_ok_q <= row_vld_q[rd_addr];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

[verif/tb_turtle_path_plotter_top.sv]
`timescale 1ns / 1ps

module tb_turtle_path_plotter_top;
	import tpp_pkg::*;

	localparam int GRID_ROWS = GRID_ROWS_DEF;
	localparam int GRID_COLS = GRID_COLS_DEF;
	localparam logic [2:0] FN_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	logic     clk;
	logic     arst_n;
	logic     start;
	tpp_cmd_t cmd;
	logic     busy;
	logic     done;
	tpp_rsp_t rsp;

	// Turtle state tracked alongside the block
	bit         floor_marks [GRID_ROWS][GRID_COLS];
	int         turtle_r;
	int         turtle_c;
	logic [1:0] turtle_hd;
	logic       pen_state;

	tpp_rsp_t report_queue [$];
	tpp_rsp_t want_rsp;
	int       error_count;
	int       cycle_count;
	bit       idle_enable;

	turtle_path_plotter_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic tpp_cmd_t mk_cmd(logic [2:0] func, int steps, int qr, int qc);
		tpp_cmd_t c;
		c.func       = func;
		c.step_count = 8'(steps);
		c.query_row  = 5'(qr);
		c.query_col  = 5'(qc);
		return c;
	endfunction

	// Free cells between the turtle and the grid edge along its heading
	function automatic int room_ahead();
		case (turtle_hd)
			HD_EAST:  return GRID_COLS - 1 - turtle_c;
			HD_SOUTH: return GRID_ROWS - 1 - turtle_r;
			HD_WEST:  return turtle_c;
			default:  return turtle_r;
		endcase
	endfunction

	function automatic void clear_plotter();
		floor_marks = '{default: 1'b0};
		turtle_r    = 0;
		turtle_c    = 0;
		turtle_hd   = HD_EAST;
		pen_state   = 1'b0;
	endfunction

	// Update tracked state for one item and queue the report it must produce
	function automatic void apply_command(tpp_cmd_t c);
		tpp_rsp_t r;
		int       n;
		r = '0;
		r.status = ST_DONE;
		n = c.step_count;
		case (c.func)
			FN_PEN_UP:   pen_state = 1'b0;
			FN_PEN_DOWN: pen_state = 1'b1;
			FN_TURN_R:   turtle_hd = turtle_hd + 2'd1;
			FN_TURN_L:   turtle_hd = turtle_hd + 2'd3;
			FN_MOVE: begin
				if (n > room_ahead()) begin
					r.status = ST_REFUSED;
				end else begin
					for (int i = 0; i <= n; i++) begin
						if (pen_state) begin
							case (turtle_hd)
								HD_EAST:  floor_marks[turtle_r][turtle_c + i] = 1'b1;
								HD_SOUTH: floor_marks[turtle_r + i][turtle_c] = 1'b1;
								HD_WEST:  floor_marks[turtle_r][turtle_c - i] = 1'b1;
								default:  floor_marks[turtle_r - i][turtle_c] = 1'b1;
							endcase
						end
					end
					case (turtle_hd)
						HD_EAST:  turtle_c = turtle_c + n;
						HD_SOUTH: turtle_r = turtle_r + n;
						HD_WEST:  turtle_c = turtle_c - n;
						default:  turtle_r = turtle_r - n;
					endcase
				end
			end
			FN_READ: begin
				if (c.query_row < GRID_ROWS && c.query_col < GRID_COLS)
					r.cell_value = floor_marks[c.query_row][c.query_col];
			end
			FN_CLEAR: clear_plotter();
			default: ;
		endcase
		r.pos_row  = 5'(turtle_r);
		r.pos_col  = 5'(turtle_c);
		r.heading  = turtle_hd;
		r.pen_down = pen_state;
		report_queue.push_back(r);
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		else if (sel < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Build a command that mostly follows a sensible drawing session
	function automatic tpp_cmd_t make_random_cmd();
		tpp_cmd_t c;
		int       pick;
		int       sel;
		c.step_count = 8'($urandom);
		c.query_row  = 5'($urandom);
		c.query_col  = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 37) begin
			c.func = FN_MOVE;
			sel = $urandom_range(0, 9);
			if (sel < 7)
				c.step_count = 8'($urandom_range(0, room_ahead()));
			else if (sel < 9)
				c.step_count = 8'($urandom_range(0, GRID_COLS - 1));
		end else if (pick < 62) begin
			c.func = FN_READ;
			// aim reads at the turtle's lines where marks are likely
			sel = $urandom_range(0, 3);
			if (sel == 0)
				c.query_row = 5'(turtle_r);
			else if (sel == 1)
				c.query_col = 5'(turtle_c);
		end else if (pick < 72) begin
			c.func = FN_PEN_DOWN;
		end else if (pick < 78) begin
			c.func = FN_PEN_UP;
		end else if (pick < 87) begin
			c.func = FN_TURN_R;
		end else if (pick < 96) begin
			c.func = FN_TURN_L;
		end else if (pick < 98) begin
			c.func = FN_CLEAR;
		end else begin
			c.func = FN_UNUSED;
		end
		return c;
	endfunction

	// Send one item and record its expected report at acceptance
	task automatic send_cmd(input tpp_cmd_t c);
		int gap;
		gap = idle_enable ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		apply_command(c);
	endtask

	// Check each report against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (report_queue.size() == 0) begin
				$error("unexpected report: %p", rsp);
				error_count++;
			end else begin
				want_rsp = report_queue.pop_front();
				if (rsp.status !== want_rsp.status) begin
					$error("status: expected %0d, actual %0d", want_rsp.status, rsp.status);
					error_count++;
				end
				if (rsp.pos_row !== want_rsp.pos_row) begin
					$error("pos_row: expected %0d, actual %0d", want_rsp.pos_row, rsp.pos_row);
					error_count++;
				end
				if (rsp.pos_col !== want_rsp.pos_col) begin
					$error("pos_col: expected %0d, actual %0d", want_rsp.pos_col, rsp.pos_col);
					error_count++;
				end
				if (rsp.heading !== want_rsp.heading) begin
					$error("heading: expected %0d, actual %0d", want_rsp.heading, rsp.heading);
					error_count++;
				end
				if (rsp.pen_down !== want_rsp.pen_down) begin
					$error("pen_down: expected %0d, actual %0d",
						want_rsp.pen_down, rsp.pen_down);
					error_count++;
				end
				if (rsp.cell_value !== want_rsp.cell_value) begin
					$error("cell_value: expected %0d, actual %0d",
						want_rsp.cell_value, rsp.cell_value);
					error_count++;
				end
			end
		end
	end

	// Walk the edges, hit refusals, wrap headings, clear and read back
	task automatic test_directed_corners();
		idle_enable = 1'b1;
		send_cmd(mk_cmd(FN_UNUSED, 255, 31, 31));
		send_cmd(mk_cmd(FN_READ, 0, 0, 0));
		send_cmd(mk_cmd(FN_PEN_DOWN, 0, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, 0, 0, 0));
		send_cmd(mk_cmd(FN_READ, 0, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, GRID_COLS - 1, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, 1, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, 255, 0, 0));
		send_cmd(mk_cmd(FN_TURN_R, 0, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, GRID_ROWS - 1, 0, 0));
		send_cmd(mk_cmd(FN_READ, 0, 31, 31));
		send_cmd(mk_cmd(FN_TURN_R, 0, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, GRID_COLS - 1, 0, 0));
		send_cmd(mk_cmd(FN_TURN_R, 0, 0, 0));
		send_cmd(mk_cmd(FN_PEN_UP, 0, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, GRID_ROWS - 1, 0, 0));
		send_cmd(mk_cmd(FN_READ, 0, 15, 0));
		send_cmd(mk_cmd(FN_READ, 0, 31, 15));
		send_cmd(mk_cmd(FN_TURN_R, 0, 0, 0));
		send_cmd(mk_cmd(FN_TURN_L, 0, 0, 0));
		send_cmd(mk_cmd(FN_MOVE, 1, 0, 0));
		send_cmd(mk_cmd(FN_CLEAR, 0, 0, 0));
		send_cmd(mk_cmd(FN_READ, 0, 0, 5));
		send_cmd(mk_cmd(FN_TURN_L, 0, 0, 0));
	endtask

	// Random drawing sessions with idle gaps on the sender side
	task automatic test_random_walk(input int count);
		idle_enable = 1'b1;
		for (int i = 0; i < count; i++)
			send_cmd(make_random_cmd());
	endtask

	// Random drawing sessions with start held high to fill the queue
	task automatic test_back_to_back(input int count);
		idle_enable = 1'b0;
		for (int i = 0; i < count; i++)
			send_cmd(make_random_cmd());
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		error_count = 0;
		cycle_count = 0;
		idle_enable = 1'b0;
		clear_plotter();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_walk(300);
		test_back_to_back(250);
		test_random_walk(280);

		// drain outstanding reports
		start <= 1'b0;
		while (report_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && report_queue.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
src/tpp_pkg.sv
src/tpp_front.sv
src/tpp_fifo.sv
src/tpp_back.sv
src/turtle_path_plotter_top.sv
verif/tb_turtle_path_plotter_top.sv
